FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define WFC_ASSERT(label, clk, rst_n, prop) \
label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("wfc assertion failed");

// clocked property, also checked during reset
`define WFC_ASSERT_NR(label, clk, prop) \
label: assert property (@(posedge clk) prop) \
	else $error("wfc reset assertion failed");

`endif

FILE: sv/wfc_pkg.sv
package wfc_pkg;

	localparam int unsigned FRAME_BITS  = 36;
	localparam int unsigned WORD_BITS   = 32;
	localparam int unsigned KEY_BITS    = 8;
	localparam int unsigned TABLE_DEPTH = 256;
	localparam int unsigned MIN_GAP     = 2;

	localparam logic [31:0] MARKER_MASK = 32'h8000_0000;
	localparam logic [31:0] TEMP_MASK   = 32'h00ff_f000;
	localparam logic [31:0] HUM_MASK    = 32'h7f00_0000;
	localparam logic [31:0] BATT_MASK   = 32'h0000_0100;

	localparam logic [7:0]  HUM_OFFSET  = 8'd28;
	localparam logic [12:0] F_OFFSET    = 13'd320;
	// x / 10 == (x * 52429) >> 19 for every x below 2^16
	localparam logic [15:0] DIV10_RECIP = 16'd52429;
	localparam int unsigned DIV10_SHIFT = 19;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_SUM,
		ST_NO_MARKER,
		ST_BAD_SIGN
	} status_t;

	typedef enum logic [1:0] {
		KIND_UNCHANGED,
		KIND_TOO_SOON,
		KIND_CHANGED,
		KIND_FIRST
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EVAL
	} state_t;

	typedef struct packed {
		status_t            status;
		logic [5:0]         sensor_code;
		logic [1:0]         channel;
		logic               battery_ok;
		logic signed [11:0] temp_c;
		logic signed [7:0]  humidity;
	} decode_t;

endpackage

FILE: sv/weather_frame_check_and_change_track_top.sv
// The accepting edge reads the sensor table and enters S_READ; S_READ registers the
// compare results and enters S_EVAL; S_EVAL decides, writes back and loads the output
// slot, but waits there while out_stall holds the previous result in the output slot.
// in_stall is high outside S_IDLE, so no new transaction is taken before S_EVAL ends.
// Reset clears the state machine, the output valid flag, the gap limit register and
// the per-sensor valid bits at once; no clearing pass, table data is
// unknown until a sensor is first seen.
module weather_frame_check_and_change_track_top
	import wfc_pkg::*;
#(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [15:0]              cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [FRAME_BITS-1:0]    frame,
	input  logic [31:0]              timestamp,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               frame_status,
	output logic [5:0]               sensor_code,
	output logic [1:0]               channel,
	output logic                     battery_ok,
	output logic signed [11:0]       temp_c_tenths,
	output logic signed [12:0]       temp_f_tenths,
	output logic signed [7:0]        humidity,
	output logic [1:0]               update_kind,
	output logic                     temp_changed,
	output logic                     humidity_changed,
	output logic                     battery_changed
);

	localparam int unsigned MEM_W = WORD_BITS + TIME_BITS;

	state_t                 state_q, state_d;
	logic [15:0]            max_gap_q;
	logic                   accept, advance;

	decode_t                in_dec, dec_s1, dec_s2;
	logic [63:0]            ts_ext;
	logic [TIME_BITS-1:0]   now_in, time_s1, time_s2;
	logic [31:0]            word_s1, word_s2;
	logic signed [16:0]     t_ext, t18;
	logic [15:0]            mag_in, mag_s1;
	logic                   neg_s1, neg_s2;

	logic [MEM_W-1:0]       mem [TABLE_DEPTH];
	logic [MEM_W-1:0]       rd_q;
	logic [31:0]            rd_word;
	logic [TIME_BITS-1:0]   rd_time;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   mem_we;

	logic [30:0]            prod_s2;
	logic [TIME_BITS-1:0]   gap_s2;
	logic                   valid_s2, tdiff_s2, hdiff_s2, bdiff_s2;

	kind_t                  kind_d;
	logic                   tf_d, hf_d, bf_d, store_d, too_soon, forced;
	logic [12:0]            quot, tf_val;

	logic                   out_valid_q;
	decode_t                out_dec_q;
	logic [12:0]            out_tf_q;
	kind_t                  out_kind_q;
	logic                   out_tflag_q, out_hflag_q, out_bflag_q;

	wfc_decode u_decode (
		.frame (frame),
		.dec   (in_dec)
	);

	assign ts_ext   = {32'b0, timestamp};
	assign now_in   = ts_ext[TIME_BITS-1:0];
	assign t_ext    = $signed({{5{in_dec.temp_c[11]}}, in_dec.temp_c});
	assign t18      = (t_ext <<< 4) + (t_ext <<< 1) + 17'sd5;
	assign mag_in   = t18[16] ? 16'(-t18) : t18[15:0];

	assign accept   = in_valid && (state_q == S_IDLE);
	assign advance  = (state_q == S_EVAL) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != S_IDLE);
	assign mem_we   = advance && store_d;

	assign rd_word  = rd_q[MEM_W-1 -: WORD_BITS];
	assign rd_time  = rd_q[TIME_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (advance) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= '0;
		end else if (cfg_we) begin
			max_gap_q <= cfg_wdata;
		end
	end

	// sensor table
	always_ff @(posedge clk) begin
		if (accept) rd_q <= mem[frame[KEY_BITS-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[word_s2[KEY_BITS-1:0]] <= {word_s2, time_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[word_s2[KEY_BITS-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1  <= in_dec;
			word_s1 <= frame[WORD_BITS-1:0];
			time_s1 <= now_in;
			mag_s1  <= mag_in;
			neg_s1  <= t18[16];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			dec_s2   <= dec_s1;
			word_s2  <= word_s1;
			time_s2  <= time_s1;
			neg_s2   <= neg_s1;
			prod_s2  <= 31'(mag_s1 * DIV10_RECIP);
			gap_s2   <= time_s1 - rd_time;
			valid_s2 <= valid_q[word_s1[KEY_BITS-1:0]];
			tdiff_s2 <= ((rd_word ^ word_s1) & TEMP_MASK) != '0;
			hdiff_s2 <= ((rd_word ^ word_s1) & HUM_MASK) != '0;
			bdiff_s2 <= ((rd_word ^ word_s1) & BATT_MASK) != '0;
		end
	end

	assign quot     = {1'b0, prod_s2[DIV10_SHIFT +: 12]};
	assign tf_val   = (neg_s2 ? -quot : quot) + F_OFFSET;
	assign too_soon = gap_s2[TIME_BITS-1] || (gap_s2 < TIME_BITS'(MIN_GAP));
	assign forced   = (max_gap_q != '0) && (gap_s2 > TIME_BITS'(max_gap_q));

	always_comb begin
		kind_d  = KIND_UNCHANGED;
		tf_d    = 1'b0;
		hf_d    = 1'b0;
		bf_d    = 1'b0;
		store_d = 1'b0;
		if (dec_s2.status != ST_OK) begin
			kind_d = KIND_UNCHANGED;
		end else if (!valid_s2) begin
			kind_d  = KIND_FIRST;
			tf_d    = 1'b1;
			hf_d    = 1'b1;
			bf_d    = 1'b1;
			store_d = 1'b1;
		end else if (too_soon) begin
			kind_d = KIND_TOO_SOON;
		end else begin
			tf_d    = forced || tdiff_s2;
			hf_d    = forced || hdiff_s2;
			bf_d    = bdiff_s2;
			store_d = tf_d || hf_d || bf_d;
			kind_d  = store_d ? KIND_CHANGED : KIND_UNCHANGED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_dec_q   <= dec_s2;
			out_tf_q    <= tf_val;
			out_kind_q  <= kind_d;
			out_tflag_q <= tf_d;
			out_hflag_q <= hf_d;
			out_bflag_q <= bf_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign frame_status     = out_dec_q.status;
	assign sensor_code      = out_dec_q.sensor_code;
	assign channel          = out_dec_q.channel;
	assign battery_ok       = out_dec_q.battery_ok;
	assign temp_c_tenths    = out_dec_q.temp_c;
	assign temp_f_tenths    = $signed(out_tf_q);
	assign humidity         = out_dec_q.humidity;
	assign update_kind      = out_kind_q;
	assign temp_changed     = out_tflag_q;
	assign humidity_changed = out_hflag_q;
	assign battery_changed  = out_bflag_q;

endmodule

FILE: sv/wfc_decode.sv
module wfc_decode
	import wfc_pkg::*;
(
	input  logic [FRAME_BITS-1:0] frame,
	output decode_t               dec
);

	logic [3:0]  sum;
	logic [2:0]  sgn;
	logic [31:0] word;

	assign word = frame[WORD_BITS-1:0];
	assign sgn  = frame[23:21];

	always_comb begin
		sum = '0;
		for (int i = 0; i < 8; i++) begin
			sum = sum + word[4*i +: 4];
		end
	end

	always_comb begin
		if (sum != frame[35:32]) begin
			dec.status = ST_BAD_SUM;
		end else if ((word & MARKER_MASK) == '0) begin
			dec.status = ST_NO_MARKER;
		end else if (sgn != 3'b000 && sgn != 3'b111) begin
			dec.status = ST_BAD_SIGN;
		end else begin
			dec.status = ST_OK;
		end
		dec.sensor_code  = {word[7:6], word[3:0]};
		dec.channel      = {word[4], word[5]};
		dec.battery_ok   = ~word[8];
		dec.temp_c       = $signed(word[23:12]);
		dec.humidity     = $signed({1'b0, word[30:24]} - HUM_OFFSET);
	end

endmodule

FILE: sv/wfc_checker.sv
`include "assert_macros.svh"

module wfc_checker
	import wfc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         frame_status,
	input logic signed [12:0] temp_f_tenths,
	input logic [1:0]         update_kind,
	input logic               temp_changed,
	input logic               humidity_changed,
	input logic               battery_changed
);

	`WFC_ASSERT(a_out_hold, clk, arst_n,
		out_valid && out_stall |=> out_valid && $stable(update_kind) && $stable(temp_f_tenths))
	`WFC_ASSERT(a_bad_frame_quiet, clk, arst_n,
		out_valid && frame_status != ST_OK |-> update_kind == KIND_UNCHANGED
		&& !temp_changed && !humidity_changed && !battery_changed)
	`WFC_ASSERT(a_first_all_flags, clk, arst_n,
		out_valid && update_kind == KIND_FIRST |-> temp_changed && humidity_changed
		&& battery_changed)
	`WFC_ASSERT(a_soon_no_flags, clk, arst_n,
		out_valid && update_kind == KIND_TOO_SOON |-> !temp_changed && !humidity_changed
		&& !battery_changed)
	`WFC_ASSERT_NR(a_reset_idle, clk, !arst_n |=> !out_valid && !in_stall)

endmodule

bind weather_frame_check_and_change_track_top wfc_checker u_wfc_checker (.*);
